/* sv/hkr_pkg.sv */
// ----------------------------------------------------------------------------
// hkr_pkg: shared types and constants for the key event to HID report block
// Holds the slot count, the usage and slot array types, and the structs that
// pass between the key map, the slot update logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package hkr_pkg;

   localparam int SlotCount = 6;
   localparam int CodeWidth = 10;
   localparam int UsageWidth = 8;
   localparam int ModWidth = 8;

   typedef logic [CodeWidth-1:0] hkr_code_type;
   typedef logic [UsageWidth-1:0] hkr_usage_type;
   typedef logic [ModWidth-1:0] hkr_mod_type;
   typedef hkr_usage_type [SlotCount-1:0] hkr_slots_type;

   localparam hkr_usage_type UsageNone = '0;

   // Result of the key code lookup.
   typedef struct packed {
      hkr_mod_type mod_mask;   // one bit set for a modifier key, else zero
      hkr_usage_type usage;    // HID usage for an ordinary key, else zero
   } hkr_key_type;

   // Result of the slot update.
   typedef struct packed {
      hkr_slots_type keys;     // slot contents after the event
      logic emit;              // the event produces a report
   } hkr_slot_result_type;

endpackage

`default_nettype wire

/* sv/hkr_if.sv */
// ----------------------------------------------------------------------------
// hkr_req_if / hkr_rsp_if: valid/ready channels of the report encoder
// The request channel carries one key event per word, the response channel
// one complete boot keyboard report per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hkr_req_if import hkr_pkg::*; ();
   logic valid;
   logic ready;
   logic [CodeWidth-1:0] key_code;
   logic pressed;

   modport source (output valid, output key_code, output pressed, input ready);
   modport sink (input valid, input key_code, input pressed, output ready);
endinterface

interface hkr_rsp_if import hkr_pkg::*; ();
   logic valid;
   logic ready;
   logic [ModWidth-1:0] modifier_bits;
   logic [UsageWidth-1:0] slot_zero;
   logic [UsageWidth-1:0] slot_one;
   logic [UsageWidth-1:0] slot_two;
   logic [UsageWidth-1:0] slot_three;
   logic [UsageWidth-1:0] slot_four;
   logic [UsageWidth-1:0] slot_five;

   modport source (output valid, output modifier_bits, output slot_zero,
                   output slot_one, output slot_two, output slot_three,
                   output slot_four, output slot_five, input ready);
   modport sink (input valid, input modifier_bits, input slot_zero,
                 input slot_one, input slot_two, input slot_three,
                 input slot_four, input slot_five, output ready);
endinterface

`default_nettype wire

/* sv/evdev_key_to_hid_keyboard_report.sv */
// ----------------------------------------------------------------------------
// evdev_key_to_hid_keyboard_report: key events to HID boot keyboard reports
// Keeps the modifier byte and six key slots and emits a full report for
// every event that changes or confirms the keyboard state.
// ----------------------------------------------------------------------------
// The block accepts one key event word per cycle on req_chan while the
// report register has room, and gives at most one report word on rsp_chan
// per event: the event waits in the input register while the key lookup,
// slot compares and state update run in a single pass, and the report is
// then loaded from there into the report register. Modifier keys always
// produce a report. Mapped ordinary keys produce a report, except a press of
// a key that is already held. Unmapped codes produce nothing and leave the
// state alone. The sustained rate is one event per cycle as long as the
// report consumer takes words; when the report register is full and not
// being taken, the event register holds its word and req_chan.ready stays
// low for as long as that register is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module evdev_key_to_hid_keyboard_report import hkr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   hkr_req_if.sink   req_chan,
   hkr_rsp_if.source rsp_chan
);

   // Input register.
   logic          in_valid_ff, in_valid_in;
   hkr_code_type  in_code_ff, in_code_in;
   logic          in_pressed_ff, in_pressed_in;

   // Keyboard state.
   hkr_mod_type   mods_ff, mods_in;
   hkr_slots_type keys_ff, keys_in;

   // Report register.
   logic          rsp_valid_ff, rsp_valid_in;
   hkr_mod_type   rsp_mods_ff, rsp_mods_in;
   hkr_slots_type rsp_keys_ff, rsp_keys_in;

   hkr_key_type         key;
   hkr_slot_result_type slot_result;
   logic                out_free;
   logic                advance;
   logic                is_mod;
   logic                is_key;
   logic                emit;

   hkr_keymap u_keymap (
      .key_code (in_code_ff),
      .key      (key)
   );

   hkr_slots u_slots (
      .keys    (keys_ff),
      .usage   (key.usage),
      .pressed (in_pressed_ff),
      .result  (slot_result)
   );

   // The report register can take a new word when it is empty or being read.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   // The event in the input register is processed whenever the report
   // register has room, whether or not the event produces a report.
   assign advance = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   assign is_mod = (key.mod_mask != '0);
   assign is_key = !is_mod && (key.usage != UsageNone);
   assign emit = is_mod || (is_key && slot_result.emit);

   always_comb begin
      in_valid_in = in_valid_ff;
      in_code_in = in_code_ff;
      in_pressed_in = in_pressed_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_code_in = req_chan.key_code;
         in_pressed_in = req_chan.pressed;
      end
   end

   always_comb begin
      mods_in = mods_ff;
      keys_in = keys_ff;
      if (advance) begin
         if (is_mod) begin
            mods_in = in_pressed_ff ? (mods_ff | key.mod_mask) : (mods_ff & ~key.mod_mask);
         end
         if (is_key) begin
            keys_in = slot_result.keys;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_mods_in = rsp_mods_ff;
      rsp_keys_in = rsp_keys_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
         rsp_mods_in = mods_in;
         rsp_keys_in = keys_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mods_ff <= '0;
         keys_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mods_ff <= mods_in;
         keys_ff <= keys_in;
      end
      in_code_ff <= in_code_in;
      in_pressed_ff <= in_pressed_in;
      rsp_mods_ff <= rsp_mods_in;
      rsp_keys_ff <= rsp_keys_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.modifier_bits = rsp_mods_ff;
   assign rsp_chan.slot_zero = rsp_keys_ff[0];
   assign rsp_chan.slot_one = rsp_keys_ff[1];
   assign rsp_chan.slot_two = rsp_keys_ff[2];
   assign rsp_chan.slot_three = rsp_keys_ff[3];
   assign rsp_chan.slot_four = rsp_keys_ff[4];
   assign rsp_chan.slot_five = rsp_keys_ff[5];

   // Held keys stay packed toward slot zero: an empty slot has only empty
   // slots after it.
   logic slots_packed;
   always_comb begin
      slots_packed = 1'b1;
      for (int i = 0; i < SlotCount - 1; i++) begin
         if (keys_ff[i] == UsageNone && keys_ff[i + 1] != UsageNone) begin
            slots_packed = 1'b0;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) slots_packed)
      else $error("key slots are not packed");

   assert property (@(posedge clock) disable iff (reset)
      !mods_ff[ModWidth-1])
      else $error("reserved modifier bit is set");

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_code_ff))
      else $error("stalled event left the input register");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> $stable(mods_ff) && $stable(keys_ff))
      else $error("state changed while the report register was blocked");

endmodule

`default_nettype wire

/* sv/hkr_keymap.sv */
// ----------------------------------------------------------------------------
// hkr_keymap: evdev key code to HID modifier bit and usage
// Fixed lookup of the supported keys; unknown codes give all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hkr_keymap import hkr_pkg::*; (
   input  hkr_code_type key_code,
   output hkr_key_type  key
);

   always_comb begin
      key.mod_mask = '0;
      key.usage = UsageNone;
      unique case (key_code)
         10'd29:  key.mod_mask = 8'h01;
         10'd42:  key.mod_mask = 8'h02;
         10'd56:  key.mod_mask = 8'h04;
         10'd125: key.mod_mask = 8'h08;
         10'd97:  key.mod_mask = 8'h10;
         10'd54:  key.mod_mask = 8'h20;
         10'd100: key.mod_mask = 8'h40;
         default: key.mod_mask = '0;
      endcase
      unique case (key_code)
         // Digit row.
         10'd2:   key.usage = 8'h1E;
         10'd3:   key.usage = 8'h1F;
         10'd4:   key.usage = 8'h20;
         10'd5:   key.usage = 8'h21;
         10'd6:   key.usage = 8'h22;
         10'd7:   key.usage = 8'h23;
         10'd8:   key.usage = 8'h24;
         10'd9:   key.usage = 8'h25;
         10'd10:  key.usage = 8'h26;
         10'd11:  key.usage = 8'h27;
         // Top letter row.
         10'd16:  key.usage = 8'h14;
         10'd17:  key.usage = 8'h1A;
         10'd18:  key.usage = 8'h08;
         10'd19:  key.usage = 8'h15;
         10'd20:  key.usage = 8'h17;
         10'd21:  key.usage = 8'h1C;
         10'd22:  key.usage = 8'h18;
         10'd23:  key.usage = 8'h0C;
         10'd24:  key.usage = 8'h12;
         10'd25:  key.usage = 8'h13;
         // Home row.
         10'd30:  key.usage = 8'h04;
         10'd31:  key.usage = 8'h16;
         10'd32:  key.usage = 8'h07;
         10'd33:  key.usage = 8'h09;
         10'd34:  key.usage = 8'h0A;
         10'd35:  key.usage = 8'h0B;
         10'd36:  key.usage = 8'h0D;
         10'd37:  key.usage = 8'h0E;
         10'd38:  key.usage = 8'h0F;
         // Bottom row.
         10'd44:  key.usage = 8'h1D;
         10'd45:  key.usage = 8'h1B;
         10'd46:  key.usage = 8'h06;
         10'd47:  key.usage = 8'h19;
         10'd48:  key.usage = 8'h05;
         10'd49:  key.usage = 8'h11;
         10'd50:  key.usage = 8'h10;
         // Punctuation, editing and cursor keys.
         10'd1:   key.usage = 8'h29;
         10'd12:  key.usage = 8'h2D;
         10'd13:  key.usage = 8'h2E;
         10'd14:  key.usage = 8'h2A;
         10'd15:  key.usage = 8'h2B;
         10'd26:  key.usage = 8'h2F;
         10'd27:  key.usage = 8'h30;
         10'd28:  key.usage = 8'h28;
         10'd39:  key.usage = 8'h33;
         10'd40:  key.usage = 8'h34;
         10'd41:  key.usage = 8'h35;
         10'd43:  key.usage = 8'h31;
         10'd51:  key.usage = 8'h36;
         10'd52:  key.usage = 8'h37;
         10'd53:  key.usage = 8'h38;
         10'd57:  key.usage = 8'h2C;
         10'd58:  key.usage = 8'h39;
         10'd103: key.usage = 8'h52;
         10'd105: key.usage = 8'h50;
         10'd106: key.usage = 8'h4F;
         10'd108: key.usage = 8'h51;
         10'd111: key.usage = 8'h4C;
         default: key.usage = UsageNone;
      endcase
   end

endmodule

`default_nettype wire

/* sv/hkr_slots.sv */
// ----------------------------------------------------------------------------
// hkr_slots: next contents of the six key slots for one ordinary key event
// A press fills the first empty slot unless the key is already held; a
// release removes the first matching slot and closes the gap.
// ----------------------------------------------------------------------------
`default_nettype none

module hkr_slots import hkr_pkg::*; (
   input  hkr_slots_type       keys,
   input  hkr_usage_type       usage,
   input  logic                pressed,
   output hkr_slot_result_type result
);

   logic [SlotCount-1:0] match;
   logic [SlotCount-1:0] empty;
   logic [SlotCount-1:0] no_match_upto;
   logic [SlotCount-1:0] first_empty;
   logic                 seen_empty;
   logic                 seen_match;

   always_comb begin
      seen_empty = 1'b0;
      seen_match = 1'b0;
      for (int i = 0; i < SlotCount; i++) begin
         match[i] = (keys[i] == usage);
         empty[i] = (keys[i] == UsageNone);
         first_empty[i] = empty[i] && !seen_empty;
         seen_empty = seen_empty || empty[i];
         seen_match = seen_match || match[i];
         no_match_upto[i] = !seen_match;
      end
   end

   always_comb begin
      result.keys = keys;
      result.emit = 1'b1;
      if (pressed) begin
         // A key already held produces no report.
         result.emit = !(|match);
         for (int i = 0; i < SlotCount; i++) begin
            if (first_empty[i]) begin
               result.keys[i] = usage;
            end
         end
      end else begin
         for (int i = 0; i < SlotCount; i++) begin
            if (!no_match_upto[i]) begin
               result.keys[i] = (i < SlotCount - 1) ? keys[(i + 1) % SlotCount] : UsageNone;
            end
         end
      end
      if (pressed && (|match)) begin
         result.keys = keys;
      end
   end

endmodule

`default_nettype wire
